/* rtl/qssm_pkg.sv */
package qssm_pkg;

  // Number of monitored servers and the width of a server index
  localparam int NUM_SERVERS = 3;
  localparam int SRV_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  // Queue between front and back end, and the result queue
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [31:0] MAX32 = '1;
  localparam logic [47:0] MAX48 = '1;
  localparam logic [63:0] MAX64 = '1;

  typedef logic [SRV_W-1:0] srv_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef struct packed {
    logic        command;
    logic [1:0]  server_id;
    logic [31:0] finish_time;
    logic [31:0] resp_time;
    logic [31:0] busy_time;
    logic [15:0] queue_length;
  } item_t;

  typedef struct packed {
    logic [1:0]  report_server;
    logic [31:0] jobs_done;
    logic [47:0] response_total;
    logic [47:0] busy_total;
    logic [31:0] peak_response;
    logic [15:0] peak_queue;
    logic [63:0] queue_area;
    logic        last_report;
  } result_t;

  // Classified, clipped request as held between front and back end
  typedef struct packed {
    op_t         op;
    srv_t        server;
    logic [31:0] fin;
    logic [31:0] resp;
    logic [31:0] busy;
    logic [15:0] qlen;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cq_stat_t;

  typedef struct packed {
    logic afford;
    logic full;
  } oq_stat_t;

endpackage

/* rtl/qssm_front.sv */
module qssm_front (
  input  qssm_pkg::item_t    item,
  input  logic               push,
  input  logic [31:0]        end_time,
  input  qssm_pkg::cq_stat_t cq_stat,
  output logic               full,
  output logic               enq,
  output qssm_pkg::cmd_t     entry
);

  logic [31:0] sid_ext;
  logic        in_range;
  logic        late;
  logic [32:0] resp_lim;
  logic [32:0] busy_lim;
  logic [32:0] resp_cut;
  logic [32:0] busy_cut;

  // Classify the request and clip late finishes back to the end time.
  // resp > (fin - end) is checked as resp + end > fin, and the cut value
  // resp + end - fin always fits in 32 bits.
  always_comb begin
    sid_ext  = 32'(item.server_id);
    in_range = sid_ext < 32'(qssm_pkg::NUM_SERVERS);
    late     = item.finish_time > end_time;
    resp_lim = {1'b0, item.resp_time} + {1'b0, end_time};
    busy_lim = {1'b0, item.busy_time} + {1'b0, end_time};
    resp_cut = resp_lim - {1'b0, item.finish_time};
    busy_cut = busy_lim - {1'b0, item.finish_time};

    entry.op     = qssm_pkg::op_t'(item.command);
    entry.server = sid_ext[qssm_pkg::SRV_W-1:0];
    entry.qlen   = item.queue_length;
    if (late) begin
      entry.fin  = end_time;
      entry.resp = (resp_lim > {1'b0, item.finish_time}) ? resp_cut[31:0] : '0;
      entry.busy = (busy_lim > {1'b0, item.finish_time}) ? busy_cut[31:0] : '0;
    end else begin
      entry.fin  = item.finish_time;
      entry.resp = item.resp_time;
      entry.busy = item.busy_time;
    end
  end

  // Out-of-range records are taken and dropped here
  assign full = cq_stat.full;
  assign enq  = push && !cq_stat.full &&
                (entry.op == qssm_pkg::OP_REPORT || in_range);

endmodule

/* rtl/qssm_cmd_queue.sv */
module qssm_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               enq,
  input  qssm_pkg::cmd_t     entry,
  input  logic               deq,
  output qssm_pkg::cmd_t     head,
  output qssm_pkg::cq_stat_t stat
);

  qssm_pkg::cmd_t                 slot [qssm_pkg::CQ_DEPTH];
  logic [qssm_pkg::CQ_AW-1:0]     wr_ptr;
  logic [qssm_pkg::CQ_AW-1:0]     rd_ptr;
  logic [qssm_pkg::CQ_AW:0]       count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (enq) begin
      slot[wr_ptr] <= entry;
    end
  end

  assign head       = slot[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (qssm_pkg::CQ_AW+1)'(qssm_pkg::CQ_DEPTH));

endmodule

/* rtl/qssm_back.sv */
module qssm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        end_time,
  input  qssm_pkg::cmd_t     head,
  input  qssm_pkg::cq_stat_t cq_stat,
  input  qssm_pkg::oq_stat_t oq_stat,
  output logic               deq,
  output logic               res_push,
  output qssm_pkg::result_t  res
);

  // Per-server statistics
  logic [31:0] job_count [qssm_pkg::NUM_SERVERS];
  logic [47:0] resp_sum  [qssm_pkg::NUM_SERVERS];
  logic [47:0] busy_sum  [qssm_pkg::NUM_SERVERS];
  logic [31:0] max_resp  [qssm_pkg::NUM_SERVERS];
  logic [15:0] max_q     [qssm_pkg::NUM_SERVERS];
  logic [15:0] prev_q    [qssm_pkg::NUM_SERVERS];
  logic [31:0] start     [qssm_pkg::NUM_SERVERS];
  logic [63:0] area_sum  [qssm_pkg::NUM_SERVERS];

  qssm_pkg::srv_t    rep_idx;
  logic              rep_last;
  logic              is_rec;
  logic              is_rep;
  qssm_pkg::srv_t    sel;
  logic [31:0]       sel_ext;
  logic [31:0]       span_to;
  logic [31:0]       span_len;
  logic [47:0]       product;
  logic              q_change;
  logic              add_go;
  logic [32:0]       jc_sum;
  logic [48:0]       rs_sum;
  logic [48:0]       bs_sum;
  logic [31:0]       jc_new;
  logic [47:0]       rs_new;
  logic [47:0]       bs_new;
  qssm_pkg::result_t snap;

  // Second stage: pending area update or report
  logic              b2_add;
  logic              b2_rep;
  qssm_pkg::srv_t    b2_idx;
  logic [47:0]       b2_w;
  qssm_pkg::result_t b2_snap;
  logic [64:0]       area_add;
  logic [63:0]       area_sat;

  // Stage one: pick the request, one shared multiplier for the area weight
  always_comb begin
    rep_last = (32'(rep_idx) == 32'(qssm_pkg::NUM_SERVERS - 1));
    is_rec   = !cq_stat.empty && head.op == qssm_pkg::OP_RECORD;
    is_rep   = !cq_stat.empty && head.op == qssm_pkg::OP_REPORT && oq_stat.afford;
    sel      = (head.op == qssm_pkg::OP_REPORT) ? rep_idx : head.server;
    sel_ext  = 32'(sel);
    span_to  = (head.op == qssm_pkg::OP_REPORT) ? end_time : head.fin;
    span_len = (span_to > start[sel]) ? (span_to - start[sel]) : '0;
    product  = 48'(span_len) * 48'(prev_q[sel]);
    q_change = prev_q[sel] != head.qlen;
    add_go   = is_rec && q_change && (start[sel] != '0);
    deq      = is_rec || (is_rep && rep_last);
  end

  // Saturating sums for a record
  always_comb begin
    jc_sum = {1'b0, job_count[sel]} + 33'd1;
    rs_sum = {1'b0, resp_sum[sel]} + 49'(head.resp);
    bs_sum = {1'b0, busy_sum[sel]} + 49'(head.busy);
    jc_new = jc_sum[32] ? qssm_pkg::MAX32 : jc_sum[31:0];
    rs_new = rs_sum[48] ? qssm_pkg::MAX48 : rs_sum[47:0];
    bs_new = bs_sum[48] ? qssm_pkg::MAX48 : bs_sum[47:0];
  end

  // Report snapshot, area filled in by stage two
  always_comb begin
    snap                = '0;
    snap.report_server  = sel_ext[1:0];
    snap.jobs_done      = job_count[sel];
    snap.response_total = resp_sum[sel];
    snap.busy_total     = busy_sum[sel];
    snap.peak_response  = max_resp[sel];
    snap.peak_queue     = max_q[sel];
    snap.last_report    = rep_last;
  end

  // Stage two: saturating area accumulate
  always_comb begin
    area_add = {1'b0, area_sum[b2_idx]} + 65'(b2_w);
    area_sat = area_add[64] ? qssm_pkg::MAX64 : area_add[63:0];
    res            = b2_snap;
    res.queue_area = area_sat;
    res_push       = b2_rep;
  end

  // Statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < qssm_pkg::NUM_SERVERS; k++) begin
        job_count[k] <= '0;
        resp_sum[k]  <= '0;
        busy_sum[k]  <= '0;
        max_resp[k]  <= '0;
        max_q[k]     <= '0;
        prev_q[k]    <= '0;
        start[k]     <= '0;
        area_sum[k]  <= '0;
      end
    end else begin
      for (int k = 0; k < qssm_pkg::NUM_SERVERS; k++) begin
        if (is_rec && sel == qssm_pkg::srv_t'(k)) begin
          job_count[k] <= jc_new;
          resp_sum[k]  <= rs_new;
          busy_sum[k]  <= bs_new;
          if (head.resp > max_resp[k]) begin
            max_resp[k] <= head.resp;
          end
          if (head.qlen > max_q[k]) begin
            max_q[k] <= head.qlen;
          end
          if (q_change) begin
            start[k] <= head.fin;
          end
          prev_q[k] <= head.qlen;
        end
        // Report clears the server, area cleared once it is read out
        if (is_rep && sel == qssm_pkg::srv_t'(k)) begin
          job_count[k] <= '0;
          resp_sum[k]  <= '0;
          busy_sum[k]  <= '0;
          max_resp[k]  <= '0;
          max_q[k]     <= '0;
          prev_q[k]    <= '0;
          start[k]     <= '0;
        end
        if (b2_add && b2_idx == qssm_pkg::srv_t'(k)) begin
          area_sum[k] <= area_sat;
        end
        if (b2_rep && b2_idx == qssm_pkg::srv_t'(k)) begin
          area_sum[k] <= '0;
        end
      end
    end
  end

  // Report sequencing and stage-two control
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_idx <= '0;
      b2_add  <= 1'b0;
      b2_rep  <= 1'b0;
    end else begin
      if (is_rep) begin
        rep_idx <= rep_last ? '0 : rep_idx + 1'b1;
      end
      b2_add <= add_go;
      b2_rep <= is_rep;
    end
  end

  // Stage-two payload
  always_ff @(posedge clk) begin
    b2_idx  <= sel;
    b2_w    <= product;
    b2_snap <= snap;
  end

endmodule

/* rtl/qssm_out_queue.sv */
module qssm_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_push,
  input  qssm_pkg::result_t  res,
  input  logic               pop,
  output logic               empty,
  output qssm_pkg::result_t  result,
  output qssm_pkg::oq_stat_t stat
);

  qssm_pkg::result_t          slot [qssm_pkg::OQ_DEPTH];
  logic [qssm_pkg::OQ_AW-1:0] wr_ptr;
  logic [qssm_pkg::OQ_AW-1:0] rd_ptr;
  logic [qssm_pkg::OQ_AW:0]   count;
  logic                       take;

  assign take = pop && !empty;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({res_push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      slot[wr_ptr] <= res;
    end
  end

  // Room for one more report: one may already be in flight
  assign empty       = (count == '0);
  assign result      = slot[rd_ptr];
  assign stat.afford = (count <= (qssm_pkg::OQ_AW+1)'(qssm_pkg::OQ_DEPTH - 2));
  assign stat.full   = (count == (qssm_pkg::OQ_AW+1)'(qssm_pkg::OQ_DEPTH));

endmodule

/* rtl/queue_server_stats_monitor.sv */
// A taken record waits in the command queue; the back end then updates its
// counts, and its queue area and each report via the stage-two register.
// Throughput: one record per cycle while no finish request holds the back
// end; a finish request holds it for each server in turn, paced by room in
// the four-deep result queue. Reset (rst, synchronous): clears end_time, all
// server statistics and both queues.
module queue_server_stats_monitor (
  input  logic              clk,
  input  logic              rst,
  input  qssm_pkg::item_t   item,
  input  logic              push,
  output logic              full,
  output qssm_pkg::result_t result,
  output logic              empty,
  input  logic              pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  logic [31:0]        end_time;
  logic               enq;
  qssm_pkg::cmd_t     entry;
  qssm_pkg::cmd_t     head;
  qssm_pkg::cq_stat_t cq_stat;
  qssm_pkg::oq_stat_t oq_stat;
  logic               deq;
  logic               res_push;
  qssm_pkg::result_t  res;

  // End-time register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      end_time <= '0;
    end else if (cfg_valid) begin
      end_time <= cfg_data;
    end
  end

  qssm_front u_front (
    .item     (item),
    .push     (push),
    .end_time (end_time),
    .cq_stat  (cq_stat),
    .full     (full),
    .enq      (enq),
    .entry    (entry)
  );

  qssm_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .enq   (enq),
    .entry (entry),
    .deq   (deq),
    .head  (head),
    .stat  (cq_stat)
  );

  qssm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .end_time (end_time),
    .head     (head),
    .cq_stat  (cq_stat),
    .oq_stat  (oq_stat),
    .deq      (deq),
    .res_push (res_push),
    .res      (res)
  );

  qssm_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .pop      (pop),
    .empty    (empty),
    .result   (result),
    .stat     (oq_stat)
  );

  // Report credit must keep the result queue from overflowing
  a_no_oq_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !oq_stat.full)
    else $error("report written into a full result queue");

  // Back end only takes a request that is there
  a_no_cq_underflow: assert property (@(posedge clk) disable iff (rst)
    deq |-> !cq_stat.empty)
    else $error("request taken from an empty queue");

  // Reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

/* tb/queue_server_stats_monitor_tb.sv */
`timescale 1ns / 100ps

module queue_server_stats_monitor_tb;

  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;    // lets a record's area land through the stage-two register
  localparam int HOLD_CYCLES   = 60;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 2000; // cycles with no handshake at all
  localparam int RANDOM_PHASE  = 99;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  qssm_pkg::item_t   item = '0;
  logic              push = 1'b0;
  logic              full;
  qssm_pkg::result_t result;
  logic              empty;
  logic              pop = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_data = '0;

  // Requests waiting for the driver, and reports waiting to come out
  qssm_pkg::item_t   pending_q[$];
  qssm_pkg::result_t report_q[$];

  int queued_count = 0;
  int taken_count  = 0;
  int error_count  = 0;
  int quiet_cycles = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_left    = 0;
  bit hold_go      = 1'b0;
  bit hold_done    = 1'b0;
  bit item_taken   = 1'b0;

  logic [31:0] sim_now = 32'd1;

  // Predicted statistics per server
  logic [31:0] end_time_cfg;
  logic [31:0] jobs      [qssm_pkg::NUM_SERVERS];
  logic [47:0] resp_tot  [qssm_pkg::NUM_SERVERS];
  logic [47:0] busy_tot  [qssm_pkg::NUM_SERVERS];
  logic [31:0] resp_peak [qssm_pkg::NUM_SERVERS];
  logic [15:0] q_peak    [qssm_pkg::NUM_SERVERS];
  logic [15:0] q_prev    [qssm_pkg::NUM_SERVERS];
  logic [31:0] q_since   [qssm_pkg::NUM_SERVERS];
  logic [63:0] area      [qssm_pkg::NUM_SERVERS];

  qssm_pkg::result_t want;

  queue_server_stats_monitor uut (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .push      (push),
    .full      (full),
    .result    (result),
    .empty     (empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [31:0] b);
    logic [48:0] sum;
    sum = {1'b0, a} + {17'd0, b};
    return sum[48] ? qssm_pkg::MAX48 : sum[47:0];
  endfunction

  function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64] ? qssm_pkg::MAX64 : sum[63:0];
  endfunction

  // Queue length held over an interval; no credit when time runs backwards
  function automatic logic [63:0] interval_area(logic [31:0] from, logic [31:0] upto,
                                                logic [15:0] qlen);
    logic [63:0] span;
    span = (upto > from) ? {32'd0, upto - from} : 64'd0;
    return span * {48'd0, qlen};
  endfunction

  task automatic clear_stats();
    for (int k = 0; k < qssm_pkg::NUM_SERVERS; k++) begin
      jobs[k]      = '0;
      resp_tot[k]  = '0;
      busy_tot[k]  = '0;
      resp_peak[k] = '0;
      q_peak[k]    = '0;
      q_prev[k]    = '0;
      q_since[k]   = '0;
      area[k]      = '0;
    end
  endtask

  // Fold one completion record into the per-server statistics
  task automatic tally_completion(qssm_pkg::item_t it);
    logic [31:0] fin;
    logic [31:0] resp;
    logic [31:0] busy;
    logic [31:0] gap;
    int          s;
    s    = int'(it.server_id);
    fin  = it.finish_time;
    resp = it.resp_time;
    busy = it.busy_time;
    if (s >= qssm_pkg::NUM_SERVERS) return;
    // late finish: pull everything back to the end time, floor at zero
    if (fin > end_time_cfg) begin
      gap  = fin - end_time_cfg;
      resp = (resp > gap) ? resp - gap : '0;
      busy = (busy > gap) ? busy - gap : '0;
      fin  = end_time_cfg;
    end
    if (jobs[s] != qssm_pkg::MAX32) jobs[s] = jobs[s] + 32'd1;
    resp_tot[s] = sat_add48(resp_tot[s], resp);
    busy_tot[s] = sat_add48(busy_tot[s], busy);
    if (resp > resp_peak[s]) resp_peak[s] = resp;
    // area only moves on a change of queue length; zero start means not open
    if (q_prev[s] != it.queue_length) begin
      if (q_since[s] != '0)
        area[s] = sat_add64(area[s], interval_area(q_since[s], fin, q_prev[s]));
      q_since[s] = fin;
    end
    q_prev[s] = it.queue_length;
    if (it.queue_length > q_peak[s]) q_peak[s] = it.queue_length;
  endtask

  // Close every area at the end time, queue one report per server, clear
  task automatic issue_reports();
    qssm_pkg::result_t r;
    for (int k = 0; k < qssm_pkg::NUM_SERVERS; k++) begin
      r.report_server  = k[1:0];
      r.jobs_done      = jobs[k];
      r.response_total = resp_tot[k];
      r.busy_total     = busy_tot[k];
      r.peak_response  = resp_peak[k];
      r.peak_queue     = q_peak[k];
      r.queue_area     = sat_add64(area[k],
                                   interval_area(q_since[k], end_time_cfg, q_prev[k]));
      r.last_report    = (k == qssm_pkg::NUM_SERVERS - 1);
      report_q.push_back(r);
    end
    clear_stats();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_error(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val)
      flag_error($sformatf("%s got %0h, expected %0h", name, got, exp_val));
  endtask

  // Monitor: reports out, register writes and requests in, all at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      item_taken   = 1'b0;
      end_time_cfg = '0;
      clear_stats();
    end else begin
      if (pop && !empty) begin
        if (report_q.size() == 0) begin
          flag_error("report with none pending");
        end else begin
          want = report_q.pop_front();
          check_field("report_server",  64'(result.report_server),
                      64'(want.report_server));
          check_field("jobs_done",      64'(result.jobs_done),
                      64'(want.jobs_done));
          check_field("response_total", 64'(result.response_total),
                      64'(want.response_total));
          check_field("busy_total",     64'(result.busy_total),
                      64'(want.busy_total));
          check_field("peak_response",  64'(result.peak_response),
                      64'(want.peak_response));
          check_field("peak_queue",     64'(result.peak_queue),
                      64'(want.peak_queue));
          check_field("queue_area",     result.queue_area, want.queue_area);
          check_field("last_report",    64'(result.last_report),
                      64'(want.last_report));
        end
      end
      if (cfg_valid && cfg_ready) end_time_cfg = cfg_data;
      item_taken = push && !full;
      if (item_taken) begin
        taken_count++;
        if (qssm_pkg::op_t'(item.command) == qssm_pkg::OP_REPORT) issue_reports();
        else tally_completion(item);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- driving

  // Sender: hold the request until taken, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || item_taken) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        item <= pending_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic qssm_pkg::item_t completion(int srv, logic [31:0] fin,
                                                 logic [31:0] resp, logic [31:0] busy,
                                                 logic [15:0] qlen);
    qssm_pkg::item_t it;
    it.command      = qssm_pkg::OP_RECORD;
    it.server_id    = srv[1:0];
    it.finish_time  = fin;
    it.resp_time    = resp;
    it.busy_time    = busy;
    it.queue_length = qlen;
    return it;
  endfunction

  // Finish request; the other fields carry junk the block must ignore
  function automatic qssm_pkg::item_t report_request();
    qssm_pkg::item_t it;
    it.command      = qssm_pkg::OP_REPORT;
    it.server_id    = 2'($urandom_range(3));
    it.finish_time  = $urandom();
    it.resp_time    = $urandom();
    it.busy_time    = $urandom();
    it.queue_length = 16'($urandom_range(65535));
    return it;
  endfunction

  // Mostly a plausible trace on a rising time base, with wild values mixed in
  function automatic qssm_pkg::item_t random_request();
    logic [31:0] fin;
    int          srv;
    if ($urandom_range(99) < 8) return report_request();
    srv     = ($urandom_range(99) < 5) ? 3 : int'($urandom_range(qssm_pkg::NUM_SERVERS - 1));
    sim_now = sim_now + $urandom_range(40);
    fin     = ($urandom_range(9) == 0) ? $urandom() : sim_now;
    return completion(srv, fin,
                      ($urandom_range(9) == 0) ? $urandom() : $urandom_range(300),
                      ($urandom_range(9) == 0) ? $urandom() : $urandom_range(300),
                      16'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                   : $urandom_range(4)));
  endfunction

  task automatic post(qssm_pkg::item_t it);
    pending_q.push_back(it);
    queued_count++;
  endtask

  // Wait for every request to be taken and every report to come out
  task automatic drain();
    do @(negedge clk);
    while (taken_count != queued_count || report_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write; called at a falling edge with the block idle
  task automatic write_end_time(logic [31:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // end time zero: every late finish clipped, report with nothing recorded
    write_end_time('0);
    @(posedge clk);
    post(report_request());
    post(completion(0, 32'd10, 32'd5, 32'd20, 16'd3));
    post(completion(1, 32'd0, 32'd7, 32'd7, 16'd0));
    post(completion(3, 32'd50, 32'd9, 32'd9, 16'd2));
    post(report_request());
    drain();

    // widest end time: extremes, backwards time, area that never opens
    write_end_time('1);
    @(posedge clk);
    post(completion(0, '1, '1, '1, '1));
    post(completion(1, 32'd100, 32'd30, 32'd10, 16'd2));
    post(completion(1, 32'd50, 32'd20, 32'd5, 16'd5));
    post(completion(1, 32'd300, 32'd10, 32'd10, 16'd5));
    post(completion(1, 32'd400, 32'd0, 32'd0, 16'd0));
    post(completion(2, 32'd0, 32'd1, 32'd1, 16'd7));
    post(completion(2, 32'd40, 32'd2, 32'd2, 16'd1));
    post(completion(3, '1, '1, '1, '1));
    post(completion(0, '1, 32'd0, 32'd0, 16'd0));
    post(report_request());
    drain();

    // open intervals late, then pull the end time back below them
    write_end_time(32'd5000);
    @(posedge clk);
    post(completion(0, 32'd4000, 32'd100, 32'd50, 16'd4));
    post(completion(0, 32'd6000, 32'd500, 32'd3000, 16'd2));
    post(completion(2, 32'd4500, 32'd900, 32'd900, 16'd9));
    post(completion(1, 32'd5000, 32'd2000, 32'd10, 16'd1));
    drain();
    write_end_time(32'd1000);
    @(posedge clk);
    post(completion(2, 32'd500, 32'd10, 32'd10, 16'd3));
    post(completion(1, 32'd1200, 32'd1500, 32'd100, 16'd6));
    post(report_request());
    drain();

    // random, sender idling lightly and receiver heavily
    write_end_time(sim_now + 32'd1500);
    @(posedge clk);
    tx_idle_pct = 22;
    rx_idle_pct = 49;
    repeat (RANDOM_PHASE) post(random_request());
    drain();

    // random, the other way round
    write_end_time('1);
    @(posedge clk);
    tx_idle_pct = 49;
    rx_idle_pct = 22;
    repeat (RANDOM_PHASE) post(random_request());
    drain();

    // no idling; receiver holds off while finish requests pile up
    write_end_time($urandom());
    @(posedge clk);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go     = 1'b1;
    for (int i = 0; i < 12; i++)
      post((i % 3 == 2) ? random_request() : report_request());
    repeat (RANDOM_PHASE) post(random_request());
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* queue_server_stats_monitor.f */
rtl/qssm_pkg.sv
rtl/qssm_front.sv
rtl/qssm_cmd_queue.sv
rtl/qssm_back.sv
rtl/qssm_out_queue.sv
rtl/queue_server_stats_monitor.sv
tb/queue_server_stats_monitor_tb.sv
